FILE: rtl/rlat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlat_pkg: shared types and constants for the recovery analysis tables
// Item codes, record types, field widths and the table request/response bundles.
// ----------------------------------------------------------------------------
package rlat_pkg;

  localparam int KEY_W         = 16;
  localparam int LSN_W         = 32;
  localparam int INDEX_W       = 5;
  localparam int TXN_COUNT_W   = 5;
  localparam int DIRTY_COUNT_W = 6;

  localparam int TXN_ENTRIES_DEF  = 16;
  localparam int PAGE_ENTRIES_DEF = 32;

  typedef enum logic [1:0] {
    KIND_CLEAR     = 2'd0,
    KIND_LOG       = 2'd1,
    KIND_READ_TXN  = 2'd2,
    KIND_READ_PAGE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REC_UPDATE       = 3'd0,
    REC_COMMIT       = 3'd1,
    REC_ABORT        = 3'd2,
    REC_COMPENSATION = 3'd3,
    REC_CHECKPOINT   = 3'd4
  } rec_type_t;

  typedef struct packed {
    logic               clear;
    logic               note;
    logic               commit;
    logic               read;
    logic [KEY_W-1:0]   key;
    logic [LSN_W-1:0]   lsn;
    logic [INDEX_W-1:0] index;
  } tbl_req_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [LSN_W-1:0] lsn;
    logic             dropped;
  } tbl_rsp_t;

endpackage

FILE: rtl/rlat_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlat_item_if: request channel
// Valid/ready channel carrying one clear, log record or read request.
// ----------------------------------------------------------------------------
interface rlat_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] lsn;
  logic [15:0] txn_id;
  logic [2:0]  rec_type;
  logic [15:0] page_id;
  logic [4:0]  index;

  modport source (output valid, kind, lsn, txn_id, rec_type, page_id, index,
                  input ready);
  modport sink   (input valid, kind, lsn, txn_id, rec_type, page_id, index,
                  output ready);
endinterface

FILE: rtl/rlat_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlat_result_if: result channel
// Valid/ready channel carrying table counts, a read entry and drop flags.
// ----------------------------------------------------------------------------
interface rlat_result_if;
  logic        valid;
  logic        ready;
  logic [4:0]  txn_count;
  logic [5:0]  dirty_count;
  logic        entry_valid;
  logic [15:0] entry_key;
  logic [31:0] entry_lsn;
  logic        txn_dropped;
  logic        page_dropped;

  modport source (output valid, txn_count, dirty_count, entry_valid, entry_key,
                  entry_lsn, txn_dropped, page_dropped,
                  input ready);
  modport sink   (input valid, txn_count, dirty_count, entry_valid, entry_key,
                  entry_lsn, txn_dropped, page_dropped,
                  output ready);
endinterface

FILE: rtl/rlat_txn_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlat_txn_table: pending transaction table
// Register table of (transaction id, last lsn) kept in insertion order;
// parallel lookup, append, in-order removal with compaction, indexed read.
// ----------------------------------------------------------------------------
module rlat_txn_table #(
  parameter int Entries = rlat_pkg::TXN_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  rlat_pkg::tbl_req_t           req,
  output rlat_pkg::tbl_rsp_t           rsp,
  output logic [$clog2(Entries+1)-1:0] count_next
);
  import rlat_pkg::*;

  localparam int CW = $clog2(Entries + 1);
  localparam int IW = $clog2(Entries);
  localparam int RW = (CW > INDEX_W) ? CW : INDEX_W;

  logic [KEY_W-1:0] ids  [Entries];
  logic [LSN_W-1:0] lsns [Entries];
  logic [CW-1:0]    used;

  logic [Entries-1:0] hit;
  logic [Entries-1:0] shift_down;
  logic               any_hit;
  logic               full;
  logic               rd_ok;
  logic [IW-1:0]      rd_addr;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      hit[i] = (CW'(i) < used) && (ids[i] == req.key);
    end
    // entries at or above the removed one move down one slot
    for (int i = 0; i < Entries; i++) begin
      shift_down[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        shift_down[i] = shift_down[i] | hit[j];
      end
    end
    any_hit = |hit;
    full    = (used == CW'(Entries));
  end

  always_comb begin
    count_next = used;
    if (req.clear) begin
      count_next = '0;
    end else if (req.note && !any_hit && !full) begin
      count_next = used + CW'(1);
    end else if (req.commit && any_hit) begin
      count_next = used - CW'(1);
    end
  end

  always_comb begin
    rd_ok       = req.read && (RW'(req.index) < RW'(used));
    rd_addr     = IW'(req.index);
    rsp.valid   = rd_ok;
    rsp.key     = rd_ok ? ids[rd_addr] : '0;
    rsp.lsn     = rd_ok ? lsns[rd_addr] : '0;
    rsp.dropped = req.note && !any_hit && full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (step) begin
      used <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && req.note) begin
      for (int i = 0; i < Entries; i++) begin
        if (hit[i]) begin
          lsns[i] <= req.lsn;
        end else if (!any_hit && (CW'(i) == used)) begin
          ids[i]  <= req.key;
          lsns[i] <= req.lsn;
        end
      end
    end else if (step && req.commit) begin
      for (int i = 0; i < Entries - 1; i++) begin
        if (shift_down[i]) begin
          ids[i]  <= ids[i+1];
          lsns[i] <= lsns[i+1];
        end
      end
    end
  end

endmodule

FILE: rtl/rlat_page_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlat_page_table: dirty page table
// Register table of (page id, recovery lsn) kept in insertion order;
// parallel lookup, lowering of recovery lsn, append, indexed read.
// ----------------------------------------------------------------------------
module rlat_page_table #(
  parameter int Entries = rlat_pkg::PAGE_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  rlat_pkg::tbl_req_t           req,
  output rlat_pkg::tbl_rsp_t           rsp,
  output logic [$clog2(Entries+1)-1:0] count_next
);
  import rlat_pkg::*;

  localparam int CW = $clog2(Entries + 1);
  localparam int IW = $clog2(Entries);
  localparam int RW = (CW > INDEX_W) ? CW : INDEX_W;

  logic [KEY_W-1:0] ids  [Entries];
  logic [LSN_W-1:0] lsns [Entries];
  logic [CW-1:0]    used;

  logic [Entries-1:0] hit;
  logic               any_hit;
  logic               full;
  logic               rd_ok;
  logic [IW-1:0]      rd_addr;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      hit[i] = (CW'(i) < used) && (ids[i] == req.key);
    end
    any_hit = |hit;
    full    = (used == CW'(Entries));
  end

  always_comb begin
    count_next = used;
    if (req.clear) begin
      count_next = '0;
    end else if (req.note && !any_hit && !full) begin
      count_next = used + CW'(1);
    end
  end

  always_comb begin
    rd_ok       = req.read && (RW'(req.index) < RW'(used));
    rd_addr     = IW'(req.index);
    rsp.valid   = rd_ok;
    rsp.key     = rd_ok ? ids[rd_addr] : '0;
    rsp.lsn     = rd_ok ? lsns[rd_addr] : '0;
    rsp.dropped = req.note && !any_hit && full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (step) begin
      used <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && req.note) begin
      for (int i = 0; i < Entries; i++) begin
        // keep the oldest lsn that dirtied the page
        if (hit[i]) begin
          if (req.lsn < lsns[i]) begin
            lsns[i] <= req.lsn;
          end
        end else if (!any_hit && (CW'(i) == used)) begin
          ids[i]  <= req.key;
          lsns[i] <= req.lsn;
        end
      end
    end
  end

endmodule

FILE: rtl/recovery_log_analysis_tables_unit.sv
`timescale 1ns / 1ps
// Each accepted request is held in the input register, where the tables look it up and are
// updated as it moves on into the result register.
// Throughput: one request per cycle while the result channel is not stalled.
// Back-pressure on the result channel holds the result register and then the input register.
// Reset (rst, synchronous) empties both tables, clears the checkpoint floor and both valid
// flags; no clearing pass, the table contents are undefined until written.
// ----------------------------------------------------------------------------
// recovery_log_analysis_tables_unit: recovery analysis table builder
// Applies log records at or above the checkpoint floor to the pending transaction and
// dirty page tables, clears both on a clear and answers indexed reads of either table.
// ----------------------------------------------------------------------------
module recovery_log_analysis_tables_unit #(
  parameter int TXN_ENTRIES  = rlat_pkg::TXN_ENTRIES_DEF,
  parameter int PAGE_ENTRIES = rlat_pkg::PAGE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [rlat_pkg::LSN_W-1:0]  cfg_wr_data,
  rlat_item_if.sink                   item,
  rlat_result_if.source               result
);
  import rlat_pkg::*;

  localparam int TCW = $clog2(TXN_ENTRIES + 1);
  localparam int PCW = $clog2(PAGE_ENTRIES + 1);

  logic [LSN_W-1:0] ckpt_floor;

  // input register
  logic               s1_valid;
  kind_t              s1_kind;
  logic [LSN_W-1:0]   s1_lsn;
  logic [KEY_W-1:0]   s1_txn_id;
  rec_type_t          s1_rec_type;
  logic [KEY_W-1:0]   s1_page_id;
  logic [INDEX_W-1:0] s1_index;

  logic step;
  logic rec_live;
  logic is_note;
  logic is_commit;

  tbl_req_t       txn_req, page_req;
  tbl_rsp_t       txn_rsp, page_rsp;
  logic [TCW-1:0] txn_count_next;
  logic [PCW-1:0] page_count_next;

  assign step       = s1_valid && (!result.valid || result.ready);
  assign item.ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      ckpt_floor <= '0;
    end else if (cfg_wr_en) begin
      ckpt_floor <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_kind     <= kind_t'(item.kind);
      s1_lsn      <= item.lsn;
      s1_txn_id   <= item.txn_id;
      s1_rec_type <= rec_type_t'(item.rec_type);
      s1_page_id  <= item.page_id;
      s1_index    <= item.index;
    end
  end

  always_comb begin
    is_note   = 1'b0;
    is_commit = 1'b0;
    case (s1_rec_type) inside
      REC_UPDATE, REC_COMPENSATION: is_note = 1'b1;
      REC_COMMIT:                   is_commit = 1'b1;
      default:                      ;
    endcase
    rec_live = (s1_kind == KIND_LOG) && (s1_lsn >= ckpt_floor);

    txn_req.clear  = (s1_kind == KIND_CLEAR);
    txn_req.note   = rec_live && is_note;
    txn_req.commit = rec_live && is_commit;
    txn_req.read   = (s1_kind == KIND_READ_TXN);
    txn_req.key    = s1_txn_id;
    txn_req.lsn    = s1_lsn;
    txn_req.index  = s1_index;

    page_req.clear  = (s1_kind == KIND_CLEAR);
    page_req.note   = rec_live && is_note;
    page_req.commit = 1'b0;
    page_req.read   = (s1_kind == KIND_READ_PAGE);
    page_req.key    = s1_page_id;
    page_req.lsn    = s1_lsn;
    page_req.index  = s1_index;
  end

  rlat_txn_table #(
    .Entries (TXN_ENTRIES)
  ) u_txn_table (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .req        (txn_req),
    .rsp        (txn_rsp),
    .count_next (txn_count_next)
  );

  rlat_page_table #(
    .Entries (PAGE_ENTRIES)
  ) u_page_table (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .req        (page_req),
    .rsp        (page_rsp),
    .count_next (page_count_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (step) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // at most one table answers a read; the other returns zeros
  always_ff @(posedge clk) begin
    if (step) begin
      result.txn_count    <= TXN_COUNT_W'(txn_count_next);
      result.dirty_count  <= DIRTY_COUNT_W'(page_count_next);
      result.entry_valid  <= txn_rsp.valid | page_rsp.valid;
      result.entry_key    <= txn_rsp.key | page_rsp.key;
      result.entry_lsn    <= txn_rsp.lsn | page_rsp.lsn;
      result.txn_dropped  <= txn_rsp.dropped;
      result.page_dropped <= page_rsp.dropped;
    end
  end

endmodule

FILE: rtl/rlat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlat_checker: port-level checks for the recovery analysis tables
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module rlat_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [4:0]  res_txn_count,
  input logic [5:0]  res_dirty_count,
  input logic        res_entry_valid,
  input logic [15:0] res_entry_key,
  input logic [31:0] res_entry_lsn,
  input logic        res_txn_dropped,
  input logic        res_page_dropped
);

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_ready_when_result_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> item_ready)
    else $error("request stalled with empty result register");

  a_empty_entry_is_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_entry_valid |-> res_entry_key == 16'd0 && res_entry_lsn == 32'd0)
    else $error("entry fields nonzero without a valid entry");

  a_read_not_dropped: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_entry_valid |-> !res_txn_dropped && !res_page_dropped)
    else $error("read result carries a drop flag");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_txn_count)
      && $stable(res_dirty_count) && $stable(res_entry_key) && $stable(res_entry_lsn))
    else $error("stalled result changed");

endmodule

bind recovery_log_analysis_tables_unit rlat_checker u_rlat_checker (
  .clk              (clk),
  .rst              (rst),
  .item_ready       (item.ready),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .res_txn_count    (result.txn_count),
  .res_dirty_count  (result.dirty_count),
  .res_entry_valid  (result.entry_valid),
  .res_entry_key    (result.entry_key),
  .res_entry_lsn    (result.entry_lsn),
  .res_txn_dropped  (result.txn_dropped),
  .res_page_dropped (result.page_dropped)
);
